// File: rtl/assert_macros.svh
// Assertion macros used by the ray box slab unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RBSI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("property violated");
`define RBSI_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RBSI_ASSERT(lbl, clk, rstn, prop)
`define RBSI_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: rtl/rbsi_pkg.sv
// Shared constants and pipeline payload types of the ray box slab unit.
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 28;
  localparam int QU_W      = FRAC_BITS + 1;
  localparam int QT_W      = TIME_BITS + 1;
  localparam int T_W       = TIME_BITS + 3;

  localparam logic [63:0]           SQ_ONE = 64'd1 << (2 * FRAC_BITS);
  localparam logic signed [T_W-1:0] T_SAT  = T_W'(2) << TIME_BITS;
  localparam logic signed [T_W-1:0] T_ONE  = T_W'(1) << TIME_BITS;

  typedef struct packed {
    logic [1:0][31:0] p;
    logic [1:0]       dneg;
    logic [1:0][31:0] dm;
    logic [30:0]      len;
    logic [1:0][33:0] nlo;
    logic [1:0][33:0] nhi;
    logic [1:0]       outside;
    logic             unit;
    logic             zero;
  } front_t;

  typedef struct packed {
    logic [1:0][31:0] p;
    logic [1:0]       dneg;
    logic [1:0][31:0] mm;
    logic [1:0][33:0] nlo;
    logic [1:0][33:0] nhi;
    logic [1:0]       outside;
    logic             zero;
  } mid_t;

  typedef struct packed {
    logic [1:0][31:0] p;
    logic [1:0]       dneg;
    logic [1:0][31:0] mm;
    logic [1:0]       moving;
    logic             miss;
    logic [3:0]       tneg;
    logic [3:0]       tsat;
  } back_t;

endpackage

// File: rtl/rbsi_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module rbsi_isqrt #(
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [63:0]   x_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int STAGES = 32;

  logic [STAGES-1:0] vld_q;
  logic [63:0]       x_q [STAGES];
  logic [63:0]       r_q [STAGES];
  logic [63:0]       x_d [STAGES];
  logic [63:0]       r_d [STAGES];
  logic [SW-1:0]     side_q [STAGES];

  function automatic logic [127:0] sq_step(input logic [63:0] x, input logic [63:0] r,
                                           input int k);
    logic [63:0] b;
    logic [63:0] t;
    b = 64'd1 << (62 - 2 * k);
    t = r + b;
    if (x >= t) begin
      return {x - t, (r >> 1) + b};
    end
    return {x, r >> 1};
  endfunction

  always_comb begin
    {x_d[0], r_d[0]} = sq_step(x_i, 64'd0, 0);
    for (int k = 1; k < STAGES; k++) begin
      {x_d[k], r_d[k]} = sq_step(x_q[k-1], r_q[k-1], k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 0; k < STAGES; k++) begin
        x_q[k] <= x_d[k];
        r_q[k] <= r_d[k];
      end
      for (int k = 1; k < STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign root_o  = r_q[STAGES-1][31:0];
  assign side_o  = side_q[STAGES-1];

endmodule

// File: rtl/rbsi_div.sv
// Pipelined restoring divider over several lanes, one quotient bit per stage.
module rbsi_div #(
  parameter int DW    = 32,
  parameter int QW    = 17,
  parameter int LANES = 2,
  parameter int SW    = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [LANES-1:0][DW:0]    num_i,
  input  logic [LANES-1:0][DW-1:0]  den_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [LANES-1:0][QW-1:0]  quo_o,
  output logic [SW-1:0]             side_o
);

  logic [QW-1:0] vld_q;
  logic [DW:0]   rem_q [QW][LANES];
  logic [DW:0]   rem_d [QW][LANES];
  logic [QW-1:0] quo_q [QW][LANES];
  logic [QW-1:0] quo_d [QW][LANES];
  logic [DW-1:0] den_q [QW][LANES];
  logic [SW-1:0] side_q [QW];

  function automatic logic [DW+1:0] div_step(input logic [DW:0] r, input logic [DW-1:0] d);
    logic          ge;
    logic [DW:0]   t;
    ge = r >= {1'b0, d};
    t  = ge ? r - {1'b0, d} : r;
    return {ge, t[DW-1:0], 1'b0};
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      {quo_d[0][l][0], rem_d[0][l]} = div_step(num_i[l], den_i[l]);
      quo_d[0][l][QW-1:1] = '0;
      for (int s = 1; s < QW; s++) begin
        {quo_d[s][l][0], rem_d[s][l]} = div_step(rem_q[s-1][l], den_q[s-1][l]);
        quo_d[s][l][QW-1:1] = quo_q[s-1][l][QW-2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int l = 0; l < LANES; l++) begin
        den_q[0][l] <= den_i[l];
      end
      for (int s = 1; s < QW; s++) begin
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          den_q[s][l] <= den_q[s-1][l];
        end
      end
      for (int s = 0; s < QW; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          quo_q[s][l] <= quo_d[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = quo_q[QW-1][l];
    end
  end

  assign valid_o = vld_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// File: rtl/ray_box_slab_intersect_2d_unit.sv
// Throughput is one item per cycle while no result waits at the output; the whole pipeline advances together.
// The square root takes 32 stages, the direction divide 17 and the slab divide 29.
// A result waiting at the output stalls every stage; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
`include "assert_macros.svh"

module ray_box_slab_intersect_2d_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, dir_x, dir_y, ray_length, box_center_x, box_center_y,
  // box_half_x, box_half_y, zero fill
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // is_hit, entry_time, hit_x, hit_y, zero fill
  output logic [87:0]  m_axis_tdata
);

  localparam int TW = rbsi_pkg::T_W;

  logic en;

  logic [31:0] in_p [2];
  logic [31:0] in_d [2];
  logic [31:0] in_c [2];
  logic [30:0] in_h [2];

  logic             s1_vld_q;
  rbsi_pkg::front_t s1_d, s1_q;
  logic [63:0]      s1_sq_d [2];
  logic [63:0]      s1_sq_q [2];

  logic             s2_vld_q;
  rbsi_pkg::front_t s2_d, s2_q;
  logic [63:0]      s2_sq_d, s2_sq_q;

  logic             sr_vld;
  logic [31:0]      sr_root;
  rbsi_pkg::front_t sr_side;

  logic                                    du_vld;
  logic [1:0][32:0]                        du_num;
  logic [1:0][31:0]                        du_den;
  logic [1:0][rbsi_pkg::QU_W-1:0]          du_quo;
  rbsi_pkg::front_t                        du_side;

  logic           s3_vld_q;
  rbsi_pkg::mid_t s3_d, s3_q;

  logic            s4_vld_q;
  rbsi_pkg::back_t s4_d, s4_q;
  logic [3:0][32:0] s4_num_d, s4_num_q;
  logic [3:0][31:0] s4_den_d, s4_den_q;

  logic                          dt_vld;
  logic [3:0][rbsi_pkg::QT_W-1:0] dt_quo;
  rbsi_pkg::back_t               dt_side;

  logic                 s5_vld_q;
  rbsi_pkg::back_t      s5_q;
  logic signed [TW-1:0] s5_tn_d [2];
  logic signed [TW-1:0] s5_tx_d [2];
  logic signed [TW-1:0] s5_tn_q [2];
  logic signed [TW-1:0] s5_tx_q [2];

  logic        s6_vld_q, s6_hit_d, s6_hit_q;
  logic [rbsi_pkg::TIME_BITS-1:0] s6_ent_d, s6_ent_q;
  logic [1:0][31:0] s6_p_q, s6_mm_q;
  logic [1:0]       s6_neg_q;

  logic        s7_vld_q, s7_hit_q;
  logic [rbsi_pkg::TIME_BITS-1:0] s7_ent_q;
  logic [31:0]      s7_off_d [2];
  logic [31:0]      s7_off_q [2];
  logic [1:0][31:0] s7_p_q;
  logic [1:0]       s7_neg_q;

  logic        out_vld_q, out_hit_d, out_hit_q;
  logic [15:0] out_et_d, out_et_q;
  logic [31:0] out_h_d [2];
  logic [31:0] out_h_q [2];

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  assign in_p[0] = s_axis_tdata[31:0];
  assign in_p[1] = s_axis_tdata[63:32];
  assign in_d[0] = s_axis_tdata[95:64];
  assign in_d[1] = s_axis_tdata[127:96];
  assign in_c[0] = s_axis_tdata[190:159];
  assign in_c[1] = s_axis_tdata[222:191];
  assign in_h[0] = s_axis_tdata[253:223];
  assign in_h[1] = s_axis_tdata[284:254];

  always_comb begin
    s1_d      = '0;
    s1_d.len  = s_axis_tdata[158:128];
    for (int a = 0; a < 2; a++) begin
      s1_d.p[a]       = in_p[a];
      s1_d.dneg[a]    = in_d[a][31];
      s1_d.dm[a]      = in_d[a][31] ? 32'd0 - in_d[a] : in_d[a];
      s1_d.nlo[a]     = {{2{in_c[a][31]}}, in_c[a]} - {3'b000, in_h[a]}
                        - {{2{in_p[a][31]}}, in_p[a]};
      s1_d.nhi[a]     = {{2{in_c[a][31]}}, in_c[a]} + {3'b000, in_h[a]}
                        - {{2{in_p[a][31]}}, in_p[a]};
      s1_d.outside[a] = !s1_d.nlo[a][33] || s1_d.nhi[a][33] || (s1_d.nhi[a] == 34'd0);
      s1_sq_d[a]      = 64'(s1_d.dm[a]) * 64'(s1_d.dm[a]);
    end
  end

  always_comb begin
    s2_sq_d    = s1_sq_q[0] + s1_sq_q[1];
    s2_d       = s1_q;
    s2_d.zero  = s2_sq_d == 64'd0;
    s2_d.unit  = s2_sq_d == rbsi_pkg::SQ_ONE;
  end

  rbsi_isqrt #(
    .SW($bits(rbsi_pkg::front_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .x_i     (s2_sq_q),
    .side_i  (s2_q),
    .valid_o (sr_vld),
    .root_o  (sr_root),
    .side_o  (sr_side)
  );

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      du_num[a] = {1'b0, sr_side.dm[a]};
      du_den[a] = sr_root;
    end
  end

  rbsi_div #(
    .DW    (32),
    .QW    (rbsi_pkg::QU_W),
    .LANES (2),
    .SW    ($bits(rbsi_pkg::front_t))
  ) u_div_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sr_vld),
    .num_i   (du_num),
    .den_i   (du_den),
    .side_i  (sr_side),
    .valid_o (du_vld),
    .quo_o   (du_quo),
    .side_o  (du_side)
  );

  always_comb begin
    logic [rbsi_pkg::QU_W-1:0]    u;
    logic [rbsi_pkg::QU_W+30:0]   prod;
    s3_d         = '0;
    s3_d.p       = du_side.p;
    s3_d.dneg    = du_side.dneg;
    s3_d.nlo     = du_side.nlo;
    s3_d.nhi     = du_side.nhi;
    s3_d.outside = du_side.outside;
    s3_d.zero    = du_side.zero;
    for (int a = 0; a < 2; a++) begin
      u          = du_side.unit ? du_side.dm[a][rbsi_pkg::QU_W-1:0] : du_quo[a];
      prod       = (rbsi_pkg::QU_W+31)'(u) * (rbsi_pkg::QU_W+31)'(du_side.len);
      s3_d.mm[a] = prod[rbsi_pkg::FRAC_BITS +: 32];
    end
  end

  always_comb begin
    logic [33:0] n;
    logic [33:0] an;
    s4_d        = '0;
    s4_d.p      = s3_q.p;
    s4_d.dneg   = s3_q.dneg;
    s4_d.mm     = s3_q.mm;
    for (int a = 0; a < 2; a++) begin
      s4_d.moving[a] = s3_q.mm[a] != 32'd0;
    end
    s4_d.miss = s3_q.zero || (s3_q.outside[0] && !s4_d.moving[0])
                || (s3_q.outside[1] && !s4_d.moving[1]);
    for (int l = 0; l < 4; l++) begin
      n              = l[0] ? s3_q.nhi[l/2] : s3_q.nlo[l/2];
      an             = n[33] ? 34'd0 - n : n;
      s4_d.tneg[l]   = n[33] ^ s3_q.dneg[l/2];
      s4_d.tsat[l]   = an >= {1'b0, s3_q.mm[l/2], 1'b0};
      s4_num_d[l]    = an[32:0];
      s4_den_d[l]    = s3_q.mm[l/2];
    end
  end

  rbsi_div #(
    .DW    (32),
    .QW    (rbsi_pkg::QT_W),
    .LANES (4),
    .SW    ($bits(rbsi_pkg::back_t))
  ) u_div_slab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .num_i   (s4_num_q),
    .den_i   (s4_den_q),
    .side_i  (s4_q),
    .valid_o (dt_vld),
    .quo_o   (dt_quo),
    .side_o  (dt_side)
  );

  always_comb begin
    logic [TW-1:0]        m0;
    logic [TW-1:0]        m1;
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    for (int a = 0; a < 2; a++) begin
      m0 = dt_side.tsat[2*a]   ? TW'(rbsi_pkg::T_SAT) : TW'(dt_quo[2*a]);
      m1 = dt_side.tsat[2*a+1] ? TW'(rbsi_pkg::T_SAT) : TW'(dt_quo[2*a+1]);
      t0 = dt_side.tneg[2*a]   ? $signed(TW'(0) - m0) : $signed(m0);
      t1 = dt_side.tneg[2*a+1] ? $signed(TW'(0) - m1) : $signed(m1);
      s5_tn_d[a] = (t0 < t1) ? t0 : t1;
      s5_tx_d[a] = (t0 < t1) ? t1 : t0;
    end
  end

  always_comb begin
    logic signed [TW-1:0] entry;
    logic signed [TW-1:0] exitt;
    entry = -rbsi_pkg::T_SAT;
    exitt = rbsi_pkg::T_SAT;
    for (int a = 0; a < 2; a++) begin
      if (s5_q.moving[a] && s5_tn_q[a] > entry) begin
        entry = s5_tn_q[a];
      end
      if (s5_q.moving[a] && s5_tx_q[a] < exitt) begin
        exitt = s5_tx_q[a];
      end
    end
    s6_hit_d = !s5_q.miss && (exitt > entry) && (exitt > 0) && (entry < rbsi_pkg::T_ONE);
    s6_ent_d = entry[TW-1] ? '0 : entry[rbsi_pkg::TIME_BITS-1:0];
  end

  always_comb begin
    logic [rbsi_pkg::TIME_BITS+31:0] prod;
    for (int a = 0; a < 2; a++) begin
      prod        = (rbsi_pkg::TIME_BITS+32)'(s6_mm_q[a])
                    * (rbsi_pkg::TIME_BITS+32)'(s6_ent_q);
      s7_off_d[a] = prod[rbsi_pkg::TIME_BITS +: 32];
    end
  end

  always_comb begin
    logic [33:0] sum;
    logic [33:0] off;
    out_hit_d = s7_hit_q;
    out_et_d  = s7_hit_q ? s7_ent_q[rbsi_pkg::TIME_BITS-1 -: 16] : 16'd0;
    for (int a = 0; a < 2; a++) begin
      off = {2'b00, s7_off_q[a]};
      sum = {{2{s7_p_q[a][31]}}, s7_p_q[a]} + (s7_neg_q[a] ? 34'd0 - off : off);
      if (!s7_hit_q) begin
        out_h_d[a] = 32'd0;
      end else if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
        out_h_d[a] = sum[31:0];
      end else if (sum[33]) begin
        out_h_d[a] = 32'h8000_0000;
      end else begin
        out_h_d[a] = 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s_axis_tvalid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= du_vld;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= dt_vld;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      out_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s1_sq_q  <= s1_sq_d;
      s2_q     <= s2_d;
      s2_sq_q  <= s2_sq_d;
      s3_q     <= s3_d;
      s4_q     <= s4_d;
      s4_num_q <= s4_num_d;
      s4_den_q <= s4_den_d;
      s5_q     <= dt_side;
      s5_tn_q  <= s5_tn_d;
      s5_tx_q  <= s5_tx_d;
      s6_hit_q <= s6_hit_d;
      s6_ent_q <= s6_ent_d;
      s6_p_q   <= s5_q.p;
      s6_mm_q  <= s5_q.mm;
      s6_neg_q <= s5_q.dneg;
      s7_hit_q <= s6_hit_q;
      s7_ent_q <= s6_ent_q;
      s7_off_q <= s7_off_d;
      s7_p_q   <= s6_p_q;
      s7_neg_q <= s6_neg_q;
      out_hit_q <= out_hit_d;
      out_et_q  <= out_et_d;
      out_h_q   <= out_h_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_h_q[1], out_h_q[0], out_et_q, out_hit_q};

  `RBSI_ASSERT(a_miss_zero, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[80:1] == 80'd0))
  `RBSI_ASSERT(a_root_nonzero, clk_i, rst_ni,
    (sr_vld && !sr_side.zero) |-> (sr_root != 32'd0))
  `RBSI_NEVER(a_dir_quo_range, clk_i, rst_ni,
    du_vld && !du_side.zero && !du_side.unit
    && ((du_quo[0] > 17'h10000) || (du_quo[1] > 17'h10000)))

endmodule
